>>> src/wsframe_pkg.sv
package wsframe_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int LEN_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] frame_len;
    logic [31:0] mask_key;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_last;
  } out_t;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  localparam logic [7:0] OPCODE_TEXT = 8'h81;
  localparam logic [7:0] LEN16_CODE  = 8'hFE;
  localparam logic [7:0] LEN64_CODE  = 8'hFF;
  localparam logic [7:0] MASK_BIT    = 8'h80;

  localparam logic [63:0] LEN7_LIMIT  = 64'd126;
  localparam logic [63:0] LEN16_LIMIT = 64'd65536;

  // header sequencer status
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_last;
    logic       done;
  } hdr_stat_t;

  // payload masking status
  typedef struct packed {
    logic       active;
    logic [7:0] frame_byte;
    logic       is_last;
  } mask_stat_t;

  function automatic logic [7:0] key_byte(input logic [31:0] k, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = k[31:24];
      2'd1:    b = k[23:16];
      2'd2:    b = k[15:8];
      default: b = k[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> src/websocket_masked_text_framer_unit.sv
// Client WebSocket text framer. A start word (mode 0) produces the frame
// header: 0x81, the length byte with the mask bit set (plus 2 or 8 extended
// length bytes), then the four key bytes, one per cycle unless the output
// stalls; it occupies the input register, and the input stalls, until its
// 6, 8 or 14 header bytes are out. A payload word (mode 1) yields one masked
// byte, so payload streams at one byte per clock with no output stall. Payload
// words beyond the announced length are consumed silently. A new start word
// abandons the frame in progress. is_last marks the frame's final byte.
module websocket_masked_text_framer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wsframe_pkg::in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wsframe_pkg::out_t out_data
);
  import wsframe_pkg::*;

  in_t        item_r;
  logic       item_v_r, item_v_nxt;
  out_t       out_r, out_nxt;
  logic       out_v_r, out_v_nxt;
  hdr_stat_t  hstat;
  mask_stat_t mstat;
  logic       is_start, adv, emit, consume, hdr_step, mask_load, mask_step, in_take;

  wsframe_hdr u_hdr (
    .clk  (clk),
    .rst_n(rst_n),
    .step (hdr_step),
    .item (item_r),
    .stat (hstat)
  );

  wsframe_mask u_mask (
    .clk  (clk),
    .rst_n(rst_n),
    .load (mask_load),
    .step (mask_step),
    .item (item_r),
    .stat (mstat)
  );

  always_comb begin
    is_start  = item_r.mode == MODE_START;
    adv       = !out_v_r || !out_stall;
    emit      = item_v_r && (is_start || mstat.active) && adv;
    consume   = item_v_r && (is_start ? (adv && hstat.done) : (!mstat.active || adv));
    hdr_step  = item_v_r && is_start && adv;
    mask_load = consume && is_start;
    mask_step = item_v_r && !is_start && mstat.active && adv;
    in_stall  = item_v_r && !consume;
    in_take   = in_valid && !in_stall;

    item_v_nxt = in_take || (item_v_r && !consume);

    out_v_nxt = emit || (out_v_r && out_stall);
    out_nxt   = out_r;
    if (emit) begin
      if (is_start) out_nxt = '{frame_byte: hstat.frame_byte, is_last: hstat.is_last};
      else out_nxt = '{frame_byte: mstat.frame_byte, is_last: mstat.is_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) item_r <= in_data;
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> src/wsframe_hdr.sv
module wsframe_hdr (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  wsframe_pkg::in_t      item,
  output wsframe_pkg::hdr_stat_t stat
);
  import wsframe_pkg::*;

  logic [3:0]  idx_r, idx_nxt;
  logic [63:0] len;
  logic        is_short, is_mid;
  logic [3:0]  key_base, last_idx, key_off;
  logic [2:0]  len_sel;
  logic [7:0]  hbyte;

  always_comb begin
    len      = 64'(item.frame_len[LEN_W-1:0]);
    is_short = len < LEN7_LIMIT;
    is_mid   = !is_short && (len < LEN16_LIMIT);
    if (is_short) begin
      key_base = 4'd2;
      last_idx = 4'd5;
    end else if (is_mid) begin
      key_base = 4'd4;
      last_idx = 4'd7;
    end else begin
      key_base = 4'd10;
      last_idx = 4'd13;
    end
    key_off = idx_r - key_base;
    len_sel = 3'(key_base - 4'd1 - idx_r);
    if (idx_r == 4'd0) begin
      hbyte = OPCODE_TEXT;
    end else if (idx_r == 4'd1) begin
      if (is_short) hbyte = MASK_BIT | {1'b0, len[6:0]};
      else if (is_mid) hbyte = LEN16_CODE;
      else hbyte = LEN64_CODE;
    end else if (idx_r < key_base) begin
      hbyte = len[{len_sel, 3'b000} +: 8];
    end else begin
      hbyte = key_byte(item.mask_key, key_off[1:0]);
    end
    stat.frame_byte = hbyte;
    stat.done       = idx_r == last_idx;
    stat.is_last    = stat.done && (len == 64'd0);
    idx_nxt         = idx_r;
    if (step) idx_nxt = stat.done ? 4'd0 : idx_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 4'd0;
    else idx_r <= idx_nxt;
  end

endmodule

>>> src/wsframe_mask.sv
module wsframe_mask (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic                   step,
  input  wsframe_pkg::in_t       item,
  output wsframe_pkg::mask_stat_t stat
);
  import wsframe_pkg::*;

  len_t        bytes_left_r;
  logic [31:0] key_r;
  logic [1:0]  pos_r;

  always_comb begin
    stat.active     = bytes_left_r != '0;
    stat.frame_byte = item.data_byte ^ key_byte(key_r, pos_r);
    stat.is_last    = bytes_left_r == len_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      key_r        <= '0;
      pos_r        <= 2'd0;
    end else if (load) begin
      bytes_left_r <= item.frame_len[LEN_W-1:0];
      key_r        <= item.mask_key;
      pos_r        <= 2'd0;
    end else if (step) begin
      bytes_left_r <= bytes_left_r - len_t'(1);
      pos_r        <= pos_r + 2'd1;
    end
  end

endmodule

>>> bench/tb_websocket_masked_text_framer_unit.sv
module tb_websocket_masked_text_framer_unit;
  import wsframe_pkg::*;

  localparam logic [63:0] LEN_MASK = (64'd1 << LENGTH_BITS) - 64'd1;
  localparam int RAND_WORDS = 385;

  typedef struct {
    in_t          w;
    int           n;
    logic [111:0] bytes;
    bit           ends;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // typed expectation travels with the word; n < 0 means use the frame model
  int           tag_n = -1;
  logic [111:0] tag_bytes = '0;
  bit           tag_ends = 1'b0;
  bit           quiet = 1'b0;

  logic [63:0] frame_left = '0;
  logic [31:0] frame_key = '0;
  logic [1:0]  frame_pos = '0;

  out_t     wire_bytes_q[$];
  dir_row_t dir_rows[$];
  int       errors = 0;
  int       n_frames = 0;
  int       n_masked = 0;
  int       n_checked = 0;
  int       rand_cnt = 0;

  websocket_masked_text_framer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("MISMATCH %s: got %02h want %02h", what, got, want);
    errors++;
  endtask

  task automatic put_byte(input logic [7:0] b, input logic last, input bit keep);
    out_t o;
    o.frame_byte = b;
    o.is_last = last;
    if (keep) wire_bytes_q.push_back(o);
  endtask

  task automatic frame_predict(input in_t w, input bit keep);
    logic [63:0] len;
    int i;
    if (w.mode == MODE_START) begin
      len = {32'd0, w.frame_len} & LEN_MASK;
      frame_left = len;
      frame_key = w.mask_key;
      frame_pos = 2'd0;
      n_frames++;
      put_byte(OPCODE_TEXT, 1'b0, keep);
      if (len < LEN7_LIMIT) begin
        put_byte(MASK_BIT | len[7:0], 1'b0, keep);
      end else if (len < LEN16_LIMIT) begin
        put_byte(LEN16_CODE, 1'b0, keep);
        put_byte(len[15:8], 1'b0, keep);
        put_byte(len[7:0], 1'b0, keep);
      end else begin
        put_byte(LEN64_CODE, 1'b0, keep);
        for (i = 0; i < 8; i++) put_byte(len[63-8*i -: 8], 1'b0, keep);
      end
      for (i = 0; i < 4; i++) put_byte(frame_key[31-8*i -: 8], (i == 3) && (len == 0), keep);
    end else if (frame_left != 0) begin
      frame_left = frame_left - 64'd1;
      put_byte(w.data_byte ^ frame_key[31-8*frame_pos -: 8], frame_left == 0, keep);
      frame_pos = frame_pos + 2'd1;
      n_masked++;
    end
  endtask

  function automatic in_t mk_word(input logic mode, input logic [31:0] len,
                                  input logic [31:0] k, input logic [7:0] d);
    in_t w;
    w.mode = mode;
    w.frame_len = len;
    w.mask_key = k;
    w.data_byte = d;
    return w;
  endfunction

  function automatic dir_row_t mk_row(input in_t w, input int n,
                                      input logic [111:0] bytes, input bit ends);
    dir_row_t r;
    r.w = w;
    r.n = n;
    r.bytes = bytes;
    r.ends = ends;
    return r;
  endfunction

  task automatic send_word(input in_t w, input int n, input logic [111:0] bytes, input bit ends);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    tag_n <= n;
    tag_bytes <= bytes;
    tag_ends <= ends;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_rand(input logic mode, input logic [31:0] len);
    send_word(mk_word(mode, len, $urandom(), 8'($urandom())), -1, '0, 1'b0);
  endtask

  always @(posedge clk) begin : watch
    int i;
    out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        frame_predict(in_data, tag_n < 0);
        for (i = 0; i < tag_n; i++) begin
          want.frame_byte = tag_bytes[111-8*i -: 8];
          want.is_last = tag_ends && (i == tag_n - 1);
          wire_bytes_q.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        if (wire_bytes_q.size() == 0) begin
          report("unexpected word", out_data.frame_byte, 8'h00);
        end else begin
          want = wire_bytes_q.pop_front();
          n_checked++;
          if (out_data.frame_byte !== want.frame_byte)
            report("frame_byte", out_data.frame_byte, want.frame_byte);
          if (out_data.is_last !== want.is_last)
            report("is_last", {7'd0, out_data.is_last}, {7'd0, want.is_last});
        end
      end
    end
  end

  always @(posedge clk) out_stall <= !quiet && ($urandom_range(99) < 15);

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stim
    int sel;
    int k;
    int nsend;
    logic [31:0] len;

    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'h3C), 0, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_START, 0, 32'h01020304, 8'h00), 6,
      {8'h81, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04, 64'h0}, 1'b1));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'hFF), 0, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_START, 3, 32'hA5C33C5A, 8'h00), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'h00), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'hFF), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'h5A), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'h11), 0, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_START, 125, 32'h0, 8'h00), 6,
      {8'h81, 8'hFD, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0}, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_START, 126, 32'hDEADBEEF, 8'h00), 8,
      {8'h81, 8'hFE, 8'h00, 8'h7E, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 48'h0}, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'hFF), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_START, 65535, 32'h0F0F0F0F, 8'h00), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_START, 65536, 32'hF0F0F0F0, 8'h00), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_START, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF), 14,
      {8'h81, 8'hFF, 32'h0, {8{8'hFF}}}, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h00), -1, '0,
      1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_START, 1, 32'h80000001, 8'h00), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'h7F), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'h80), 0, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_START, 5, 32'h12345678, 8'h00), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'h41), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'h42), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_START, 2, 32'h9ABCDEF0, 8'h00), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'h43), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'h44), -1, '0, 1'b0));
    dir_rows.push_back(mk_row(mk_word(MODE_DATA, 0, 0, 8'h45), 0, '0, 1'b0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].w, dir_rows[i].n, dir_rows[i].bytes, dir_rows[i].ends);

    while (rand_cnt < RAND_WORDS) begin
      quiet <= (rand_cnt >= 120) && (rand_cnt < 220);
      sel = $urandom_range(99);
      if (sel < 55) len = $urandom_range(12);
      else if (sel < 70) len = $urandom_range(125, 13);
      else if (sel < 78) len = $urandom_range(140, 126);
      else if (sel < 84) begin
        case ($urandom_range(4))
          0: len = 32'd125;
          1: len = 32'd126;
          2: len = 32'd65535;
          3: len = 32'd65536;
          default: len = 32'hFFFFFFFF;
        endcase
      end else if (sel < 92) len = $urandom_range(65535, 141);
      else len = $urandom();
      send_rand(MODE_START, len);
      rand_cnt++;
      if (len <= 140) nsend = ($urandom_range(99) < 80) ? int'(len) : $urandom_range(len);
      else nsend = $urandom_range(8);
      for (k = 0; k < nsend && rand_cnt < RAND_WORDS; k++) begin
        send_rand(MODE_DATA, $urandom());
        rand_cnt++;
      end
      // words past the end of the frame, then an odd word of noise
      if (nsend == int'(len) && $urandom_range(99) < 25)
        repeat ($urandom_range(3, 1)) send_rand(MODE_DATA, $urandom());
      if ($urandom_range(99) < 5)
        send_rand(logic'($urandom_range(1)), $urandom());
    end

    in_valid <= 1'b0;
    quiet <= 1'b0;
    while (wire_bytes_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d frame starts and %0d masked payload bytes; %0d wire bytes checked.",
             n_frames, n_masked, n_checked);
    $display("Length forms 7/16/64-bit, restarts, empty frames and surplus words exercised.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> websocket_masked_text_framer_unit.f
src/wsframe_pkg.sv
src/wsframe_hdr.sv
src/wsframe_mask.sv
src/websocket_masked_text_framer_unit.sv
bench/tb_websocket_masked_text_framer_unit.sv
